/* sv/jfwin_pkg.sv */
// Shared constants and controller/datapath interface types for the job queue.
// No dependencies; imported by jfwin_ctrl, jfwin_dp and the top level.
`timescale 1ns / 1ps
`default_nettype none

package jfwin_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 1024;
    localparam int MAX_BATCH   = 64;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int KIND_W  = 2;
    localparam int BATCH_W = 7;
    localparam int TIME_W  = 32;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SERVE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POLL   = 2'd2;

    localparam logic [BATCH_W-1:0] BATCH_MAX = BATCH_W'(MAX_BATCH);
    localparam logic [ADDR_W-1:0]  ADDR_LAST = ADDR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0]   CNT_FULL  = CNT_W'(QUEUE_DEPTH);

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // capture an accepted item
        logic ins_write;   // store one job at the tail
        logic set_ovf;     // note that an insert dropped jobs
        logic srv_read;    // read one job at the head and pop it
        logic emit_job;    // load the output register with a served job
        logic emit_single; // load the output register with the single result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              remain_zero;
        logic              full;
        logic              empty;
        logic              out_free;
    } t_status;

endpackage

`default_nettype wire

/* sv/jfwin_dp.sv */
// Datapath of the job queue: job store, head/tail/length, idle flag, output register.
// Depends on jfwin_pkg; driven by commands from jfwin_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module jfwin_dp
    import jfwin_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    output t_status                  o_status,
    input  wire logic [KIND_W-1:0]   i_kind,
    input  wire logic [BATCH_W-1:0]  i_count,
    input  wire logic [TIME_W-1:0]   i_now_time,
    input  wire logic                i_stall,
    output logic                     o_valid,
    output logic [TIME_W-1:0]        o_job_time,
    output logic                     o_served,
    output logic                     o_last,
    output logic [CNT_W-1:0]         o_queue_length,
    output logic                     o_idle_notice,
    output logic                     o_overflow
);

    // Job store, reset undefined
    logic [TIME_W-1:0] mem [QUEUE_DEPTH];

    // Item registers
    logic [KIND_W-1:0]  r_kind;
    logic [BATCH_W-1:0] r_remain;
    logic [TIME_W-1:0]  r_now;
    logic               r_had_work;
    logic               r_ovf;
    logic [TIME_W-1:0]  r_rd_data;

    // Queue state
    logic [ADDR_W-1:0]  r_head;
    logic [ADDR_W-1:0]  r_tail;
    logic [CNT_W-1:0]   r_count;
    logic               r_idle;

    // Output register
    logic               r_o_valid;
    logic [TIME_W-1:0]  r_o_time;
    logic               r_o_served;
    logic               r_o_last;
    logic [CNT_W-1:0]   r_o_qlen;
    logic               r_o_idle;
    logic               r_o_ovf;

    logic [BATCH_W-1:0] n_count_sat;
    logic               n_last_job;
    logic               n_idle_set;
    logic               n_out_free;

    // Saturate the batch size and decode end-of-serve conditions
    always_comb begin
        n_count_sat = (i_count > BATCH_MAX) ? BATCH_MAX : i_count;
        n_last_job  = (r_remain == '0) || (r_count == '0);
        n_idle_set  = r_had_work && (r_count == '0);
        n_out_free  = !r_o_valid || !i_stall;
    end

    // Job store write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_write) begin
            mem[r_tail] <= r_now;
        end
        if (i_cmd.srv_read) begin
            r_rd_data <= mem[r_head];
        end
    end

    // Item capture, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind     <= i_kind;
            r_remain   <= n_count_sat;
            r_now      <= i_now_time;
            r_had_work <= (n_count_sat != '0) || (r_count != '0);
        end else if (i_cmd.ins_write || i_cmd.srv_read) begin
            r_remain   <= r_remain - BATCH_W'(1);
        end
    end

    // Queue pointers, length, idle and overflow flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_idle  <= 1'b1;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_ovf <= 1'b0;
            end else if (i_cmd.set_ovf) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.ins_write) begin
                r_tail  <= (r_tail == ADDR_LAST) ? '0 : r_tail + ADDR_W'(1);
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.srv_read) begin
                r_head  <= (r_head == ADDR_LAST) ? '0 : r_head + ADDR_W'(1);
                r_count <= r_count - CNT_W'(1);
            end
            // serve that drains the queue marks the server idle
            if (i_cmd.emit_job && n_last_job && n_idle_set) begin
                r_idle <= 1'b1;
            end
            if (i_cmd.emit_single) begin
                if (r_kind == KIND_POLL) begin
                    r_idle <= 1'b0;
                end else if (r_kind == KIND_SERVE && n_idle_set) begin
                    r_idle <= 1'b1;
                end
            end
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit_job || i_cmd.emit_single) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_job) begin
            r_o_time   <= r_rd_data;
            r_o_served <= 1'b1;
            r_o_last   <= n_last_job;
            r_o_qlen   <= r_count;
            r_o_idle   <= 1'b0;
            r_o_ovf    <= 1'b0;
        end else if (i_cmd.emit_single) begin
            r_o_time   <= '0;
            r_o_served <= 1'b0;
            r_o_last   <= 1'b1;
            r_o_qlen   <= r_count;
            r_o_idle   <= (r_kind == KIND_POLL) ? r_idle : 1'b0;
            r_o_ovf    <= (r_kind == KIND_INSERT) ? r_ovf : 1'b0;
        end
    end

    // Status to controller
    always_comb begin
        o_status.kind        = r_kind;
        o_status.remain_zero = (r_remain == '0);
        o_status.full        = (r_count == CNT_FULL);
        o_status.empty       = (r_count == '0);
        o_status.out_free    = n_out_free;
    end

    assign o_valid         = r_o_valid;
    assign o_job_time      = r_o_time;
    assign o_served        = r_o_served;
    assign o_last          = r_o_last;
    assign o_queue_length  = r_o_qlen;
    assign o_idle_notice   = r_o_idle;
    assign o_overflow      = r_o_ovf;

endmodule

`default_nettype wire

/* sv/jfwin_ctrl.sv */
// Controller state machine of the job queue: sequences insert, serve and poll items.
// Depends on jfwin_pkg; drives jfwin_dp through t_cmd and reads t_status.
`timescale 1ns / 1ps
`default_nettype none

module jfwin_ctrl
    import jfwin_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS,
        S_SRV_RD,
        S_SRV_EMIT,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_stall;
    logic   n_stall;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        n_stall = r_stall;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_stall    = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_status.kind)
                    KIND_INSERT: n_state = S_INS;
                    KIND_SERVE: begin
                        if (i_status.remain_zero || i_status.empty) begin
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_SRV_RD;
                        end
                    end
                    default: n_state = S_EMIT;
                endcase
            end
            // one job stored per cycle until batch done or queue full
            S_INS: begin
                if (i_status.remain_zero) begin
                    n_state = S_EMIT;
                end else if (i_status.full) begin
                    o_cmd.set_ovf = 1'b1;
                    n_state       = S_EMIT;
                end else begin
                    o_cmd.ins_write = 1'b1;
                end
            end
            S_SRV_RD: begin
                o_cmd.srv_read = 1'b1;
                n_state        = S_SRV_EMIT;
            end
            // hand the read job to the output register
            S_SRV_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_job = 1'b1;
                    if (i_status.remain_zero || i_status.empty) begin
                        n_stall = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_SRV_RD;
                    end
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_single = 1'b1;
                    n_stall           = 1'b0;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_stall = 1'b0;
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= n_stall;
        end
    end

    assign o_stall = r_stall;

endmodule

`default_nettype wire

/* sv/job_fifo_with_idle_notice_top.sv */
// Top level of the job queue with idle notice: controller plus datapath.
// Depends on jfwin_pkg, jfwin_ctrl and jfwin_dp.
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------------------
//   in      | i_valid / o_stall  | i_kind, i_count, i_now_time
//   out     | o_valid / i_stall  | o_job_time, o_served, o_last,
//           |                    | o_queue_length, o_idle_notice, o_overflow
//
// One item at a time. Insert stores one job per cycle into the store until the batch
// is done or the queue is full; serve reads each job from the store, then loads it
// into the output register; poll, empty serve and unused kind give one result.
// An output stall holds the controller in its emit step,
// while the output register lets the next item be accepted behind a waiting result.
// Reset is synchronous, active low; the job store needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module job_fifo_with_idle_notice_top
    import jfwin_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [KIND_W-1:0]   i_kind,
    input  wire logic [BATCH_W-1:0]  i_count,
    input  wire logic [TIME_W-1:0]   i_now_time,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [TIME_W-1:0]        o_job_time,
    output logic                     o_served,
    output logic                     o_last,
    output logic [CNT_W-1:0]         o_queue_length,
    output logic                     o_idle_notice,
    output logic                     o_overflow
);

    t_cmd    w_cmd;
    t_status w_status;

    jfwin_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    jfwin_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_kind          (i_kind),
        .i_count         (i_count),
        .i_now_time      (i_now_time),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_job_time      (o_job_time),
        .o_served        (o_served),
        .o_last          (o_last),
        .o_queue_length  (o_queue_length),
        .o_idle_notice   (o_idle_notice),
        .o_overflow      (o_overflow)
    );

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for job_fifo_with_idle_notice_top: random insert/serve/poll traffic
// with a shadow job queue that predicts every result. Depends on jfwin_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
    import jfwin_pkg::*;

    // Kind code the block leaves unused
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    // One result item of the output channel, in port order
    typedef struct packed {
        logic [TIME_W-1:0] job_time;
        logic              served;
        logic              last;
        logic [CNT_W-1:0]  queue_length;
        logic              idle_notice;
        logic              overflow;
    } t_job_result;

    // Shadow of the job queue: predicts results per accepted item, checks each result
    class t_queue_shadow;
        logic [TIME_W-1:0] stored_times[$];
        bit                idle_copy;
        t_job_result       due_results[$];
        int unsigned       mismatches;

        function new();
            idle_copy  = 1'b1;
            mismatches = 0;
        endfunction

        function void note_item(logic [KIND_W-1:0] kind, logic [BATCH_W-1:0] count,
                                logic [TIME_W-1:0] now_time);
            int          batch;
            int          take;
            bit          dropped;
            bit          had_work;
            t_job_result r;
            batch   = (count > BATCH_MAX) ? MAX_BATCH : int'(count);
            dropped = 1'b0;
            r       = '0;
            r.last  = 1'b1;
            case (kind)
                KIND_INSERT: begin
                    for (int j = 0; j < batch; j++) begin
                        if (stored_times.size() >= QUEUE_DEPTH) begin
                            dropped = 1'b1;
                            break;
                        end
                        stored_times.insert(stored_times.size(), now_time);
                    end
                    r.overflow     = dropped;
                    r.queue_length = CNT_W'(stored_times.size());
                    due_results.insert(due_results.size(), r);
                end
                KIND_SERVE: begin
                    had_work = (batch + stored_times.size()) > 0;
                    take     = (stored_times.size() < batch) ? stored_times.size() : batch;
                    for (int j = 0; j < take; j++) begin
                        r.job_time      = stored_times.pop_front();
                        r.served        = 1'b1;
                        r.last          = (j == take - 1);
                        r.queue_length  = CNT_W'(stored_times.size());
                        due_results.insert(due_results.size(), r);
                    end
                    if (had_work && stored_times.size() == 0)
                        idle_copy = 1'b1;
                    // nothing served: one empty result
                    if (take == 0) begin
                        r.queue_length = CNT_W'(stored_times.size());
                        due_results.insert(due_results.size(), r);
                    end
                end
                KIND_POLL: begin
                    r.idle_notice  = idle_copy;
                    r.queue_length = CNT_W'(stored_times.size());
                    idle_copy      = 1'b0;
                    due_results.insert(due_results.size(), r);
                end
                default: begin
                    r.queue_length = CNT_W'(stored_times.size());
                    due_results.insert(due_results.size(), r);
                end
            endcase
        endfunction

        function void flag(string field, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
            mismatches++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
        endfunction

        function void check_result(t_job_result got);
            t_job_result want;
            if (due_results.size() == 0) begin
                mismatches++;
                $display("%0t: result with none expected, actual %0h", $time, got);
                return;
            end
            want = due_results.pop_front();
            if (got.job_time !== want.job_time)
                flag("job_time", want.job_time, got.job_time);
            if (got.served !== want.served)
                flag("served", want.served, got.served);
            if (got.last !== want.last)
                flag("last", want.last, got.last);
            if (got.queue_length !== want.queue_length)
                flag("queue_length", want.queue_length, got.queue_length);
            if (got.idle_notice !== want.idle_notice)
                flag("idle_notice", want.idle_notice, got.idle_notice);
            if (got.overflow !== want.overflow)
                flag("overflow", want.overflow, got.overflow);
        endfunction
    endclass

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_valid    = 1'b0;
    logic [KIND_W-1:0]  i_kind     = '0;
    logic [BATCH_W-1:0] i_count    = '0;
    logic [TIME_W-1:0]  i_now_time = '0;
    logic               i_stall    = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [TIME_W-1:0]  o_job_time;
    logic               o_served;
    logic               o_last;
    logic [CNT_W-1:0]   o_queue_length;
    logic               o_idle_notice;
    logic               o_overflow;

    t_queue_shadow     book;
    int                burst_left = 0;
    int                items_sent = 0;
    int unsigned       rx_cycle   = 0;
    int                stall_run  = 0;

    job_fifo_with_idle_notice_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_count         (i_count),
        .i_now_time      (i_now_time),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_job_time      (o_job_time),
        .o_served        (o_served),
        .o_last          (o_last),
        .o_queue_length  (o_queue_length),
        .o_idle_notice   (o_idle_notice),
        .o_overflow      (o_overflow)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Overall time limit
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Result side: check accepted items, then pick the next stall value
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            book.check_result(t_job_result'({o_job_time, o_served, o_last,
                                              o_queue_length, o_idle_notice, o_overflow}));
        rx_cycle <= rx_cycle + 1;
        // stall mode per window, in turn: 0 never stalls, 2 stalls heavily, 1 and 3 lightly
        if (stall_run > 0) begin
            stall_run <= stall_run - 1;
        end else if ((rx_cycle / 300) % 4 != 0 &&
                     $urandom_range(99) < (((rx_cycle / 300) % 4 == 2) ? 50 : 20)) begin
            i_stall   <= 1'b1;
            stall_run <= $urandom_range(((rx_cycle / 300) % 4 == 2) ? 7 : 2);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Drop valid for the given number of cycles; payload is scrambled while no item is offered
    task automatic hold_off(int cycles);
        if (cycles > 0) begin
            i_valid    <= 1'b0;
            i_kind     <= KIND_W'($urandom);
            i_count    <= BATCH_W'($urandom);
            i_now_time <= $urandom;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Offer one item in burst pacing and wait until it is taken
    task automatic offer(logic [KIND_W-1:0] kind, logic [BATCH_W-1:0] count,
                         logic [TIME_W-1:0] now_time);
        if (burst_left == 0) begin
            if (items_sent < 150 || items_sent >= 200)
                hold_off($urandom_range(0, 10));
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        i_valid    <= 1'b1;
        i_kind     <= kind;
        i_count    <= count;
        i_now_time <= now_time;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        book.note_item(kind, count, now_time);
        items_sent++;
    endtask

    initial begin
        int                 phase;
        int                 roll;
        logic [KIND_W-1:0]  kind;
        logic [BATCH_W-1:0] count;
        book = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: idle flag from reset, serve on an empty queue, count saturation
        offer(KIND_POLL, 7'd0, 32'd0);
        offer(KIND_POLL, 7'd0, 32'd0);
        offer(KIND_SERVE, 7'd0, 32'd0);
        offer(KIND_SERVE, 7'd5, 32'd0);
        offer(KIND_POLL, 7'd0, 32'd0);
        offer(KIND_INSERT, 7'd0, 32'hFFFF_FFFF);
        offer(KIND_INSERT, 7'd127, 32'hFFFF_FFFF);
        offer(KIND_SERVE, 7'd0, 32'd0);
        offer(KIND_SERVE, 7'd127, 32'd0);
        offer(KIND_SPARE, 7'd127, $urandom);
        // fill to the brim, then push into a full queue
        for (int f = 0; f < 16; f++)
            offer(KIND_INSERT, f[0] ? 7'd127 : 7'd64, (f == 0) ? 32'd0 : $urandom);
        offer(KIND_INSERT, 7'd1, $urandom);
        offer(KIND_INSERT, 7'd0, $urandom);

        // Random: phases that lean to filling, to draining, or neither
        for (int n = 0; n < 330; n++) begin
            phase = (n / 60) % 3;
            roll  = $urandom_range(99);
            if (roll < ((phase == 0) ? 55 : (phase == 1) ? 20 : 40))
                kind = KIND_INSERT;
            else if (roll < ((phase == 2) ? 75 : 80))
                kind = KIND_SERVE;
            else if (roll < 95)
                kind = KIND_POLL;
            else
                kind = KIND_SPARE;
            roll = $urandom_range(99);
            if ((phase == 0 && kind == KIND_INSERT) || (phase == 1 && kind == KIND_SERVE))
                roll = (roll < 50) ? 60 + roll / 2 : roll;
            if (roll < 55)
                count = BATCH_W'($urandom_range(0, 6));
            else if (roll < 88)
                count = BATCH_W'($urandom_range(7, 64));
            else
                count = BATCH_W'($urandom_range(65, 127));
            offer(kind, count, $urandom);
        end
        i_valid <= 1'b0;

        // Drain, then leave room for any stray result
        while (book.due_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (book.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
sv/jfwin_pkg.sv
sv/jfwin_dp.sv
sv/jfwin_ctrl.sv
sv/job_fifo_with_idle_notice_top.sv
dv/testbench.sv
